/* hdl/ism_pkg.sv */
// ----------------------------------------------------------------------------
// ism_pkg: shared types and constants of the interval subscription matcher
// Field widths, operation codes and the table entry layouts.
// ----------------------------------------------------------------------------
package ism_pkg;

    localparam int OP_W      = 2;
    localparam int SUB_IDX_W = 10;
    localparam int SLOT_IN_W = 3;
    localparam int CNT_W     = 4;
    localparam int ATTR_W    = 5;
    localparam int VAL_W     = 20;
    localparam int COUNT_W   = 11;
    // Every attribute number that fits the attribute field has an event slot.
    localparam int DIM       = 1 << ATTR_W;

    localparam logic [OP_W-1:0] OP_PRED  = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB   = 2'd1;
    localparam logic [OP_W-1:0] OP_EVENT = 2'd2;

    typedef struct packed {
        logic             active;
        logic [CNT_W-1:0] count;
    } sub_entry_t;

    typedef struct packed {
        logic [ATTR_W-1:0] attr;
        logic [VAL_W-1:0]  low;
        logic [VAL_W-1:0]  high;
    } pred_entry_t;

endpackage

/* hdl/ism_sub_table.sv */
// ----------------------------------------------------------------------------
// ism_sub_table: subscription table memory
// One entry per subscription holding its active mark and predicate count.
// ----------------------------------------------------------------------------
module ism_sub_table #(
    parameter int SUBS  = 1024,
    parameter int SUB_W = 10
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [SUB_W-1:0]    wr_addr,
    input  ism_pkg::sub_entry_t wr_data,
    input  logic [SUB_W-1:0]    rd_addr,
    output ism_pkg::sub_entry_t rd_data
);
    import ism_pkg::*;

    sub_entry_t mem [SUBS];
    sub_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/ism_pred_table.sv */
// ----------------------------------------------------------------------------
// ism_pred_table: predicate memory
// One row of predicate slots per subscription, addressed as {subscription, slot}.
// ----------------------------------------------------------------------------
module ism_pred_table #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  ism_pkg::pred_entry_t wr_data,
    input  logic [ADDR_W-1:0]    rd_addr,
    output ism_pkg::pred_entry_t rd_data
);
    import ism_pkg::*;

    pred_entry_t mem [DEPTH];
    pred_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/ism_event_check.sv */
// ----------------------------------------------------------------------------
// ism_event_check: event latch and interval compare unit
// Holds the current event's values and present marks and tests one predicate.
// ----------------------------------------------------------------------------
module ism_event_check (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [ism_pkg::ATTR_W-1:0]  wr_attr,
    input  logic [ism_pkg::VAL_W-1:0]   wr_value,
    input  logic                        clr_present,
    input  ism_pkg::pred_entry_t        pred,
    output logic                        pred_ok
);
    import ism_pkg::*;

    logic [VAL_W-1:0] event_val_reg [DIM];
    logic [DIM-1:0]   present_reg;
    logic [DIM-1:0]   present_next;
    logic [VAL_W-1:0] cur_value;

    always_comb begin
        present_next = present_reg;
        if (clr_present) begin
            present_next = '0;
        end else if (wr_en) begin
            present_next[wr_attr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= '0;
        end else begin
            present_reg <= present_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            event_val_reg[wr_attr] <= wr_value;
        end
    end

    // The predicate holds when its attribute is in the event and the value
    // lies inside the closed interval.
    assign cur_value = event_val_reg[pred.attr];
    assign pred_ok   = present_reg[pred.attr] && (pred.low <= cur_value)
                       && (cur_value <= pred.high);

endmodule

/* hdl/interval_subscription_matcher_unit.sv */
// ----------------------------------------------------------------------------
// interval_subscription_matcher_unit: content-based interval subscription matcher
// Holds a subscription table and counts the subscriptions an event satisfies.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel carries one request per handshake. A predicate write or a
// subscription update (count and active mark) is absorbed while the block
// stays idle, as is an event pair that is not marked last. An event pair
// marked last starts a walk over the whole subscription table, and s_ready
// stays low until the walk's count is loaded into the m_ channel's output
// register. The walk visits the subscriptions in turn and tests their
// predicates one at a time in the single interval compare unit fed by the
// predicate memory port, stopping at the first predicate that fails.
// The output register parts the two sides: new requests are taken while a
// count still waits for m_ready. Only if a second walk finishes while the
// first count is still held does the block wait for the receiver.
// After reset the block runs a pass that clears the active marks and counts
// of the subscription table and holds s_ready low during that pass. Reset also
// empties the current event; predicates are undefined until written.
// ----------------------------------------------------------------------------
module interval_subscription_matcher_unit #(
    parameter int SUBS      = 1024,
    parameter int MAX_PREDS = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ism_pkg::OP_W-1:0]       s_op,
    input  logic [ism_pkg::SUB_IDX_W-1:0]  s_sub_index,
    input  logic [ism_pkg::SLOT_IN_W-1:0]  s_pred_slot,
    input  logic [ism_pkg::CNT_W-1:0]      s_pred_count,
    input  logic                           s_active,
    input  logic [ism_pkg::ATTR_W-1:0]     s_attribute,
    input  logic [ism_pkg::VAL_W-1:0]      s_low_bound,
    input  logic [ism_pkg::VAL_W-1:0]      s_high_bound,
    input  logic [ism_pkg::VAL_W-1:0]      s_event_value,
    input  logic                           s_last,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ism_pkg::COUNT_W-1:0]    m_match_count
);
    import ism_pkg::*;

    localparam int SUB_W   = (SUBS > 1) ? $clog2(SUBS) : 1;
    localparam int SLOT_W  = (MAX_PREDS > 1) ? $clog2(MAX_PREDS) : 1;
    localparam int PADDR_W = SUB_W + SLOT_W;
    localparam int PDEPTH  = SUBS << SLOT_W;

    // Sequencer states.
    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_SUB_CHK  = 3'd2;
    localparam logic [2:0] ST_PRED_CHK = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [SUB_W-1:0]   sub_ptr_reg, sub_ptr_next;
    logic [SLOT_W-1:0]  k_reg, k_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic               m_valid_reg, m_valid_next;
    logic [COUNT_W-1:0] m_count_reg, m_count_next;

    logic        accept;
    logic        sub_in_range;
    logic        slot_in_range;
    logic        sub_last;
    logic        sub_done;
    logic        sub_hit;
    logic        clr_present;
    logic        event_wr;
    logic [CNT_W-1:0] sat_count;

    logic               sub_wr_en;
    logic [SUB_W-1:0]   sub_wr_addr;
    sub_entry_t         sub_wr_data;
    sub_entry_t         sub_q;
    logic               pred_wr_en;
    logic [PADDR_W-1:0] pred_wr_addr;
    logic [PADDR_W-1:0] pred_rd_addr;
    pred_entry_t        pred_wr_data;
    pred_entry_t        pred_q;
    logic               pred_ok;

    assign s_ready       = (state_reg == ST_IDLE);
    assign accept        = s_valid && s_ready;
    assign sub_in_range  = 32'(s_sub_index) < SUBS;
    assign slot_in_range = 32'(s_pred_slot) < MAX_PREDS;
    assign sub_last      = 32'(sub_ptr_reg) == (SUBS - 1);
    assign sat_count     = (32'(s_pred_count) > MAX_PREDS) ? CNT_W'(MAX_PREDS)
                                                             : s_pred_count;

    // Table writes come from requests while idle, and from the clearing
    // pass after reset, which zeroes one subscription per cycle.
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            sub_wr_en   = 1'b1;
            sub_wr_addr = sub_ptr_reg;
            sub_wr_data = '0;
        end else begin
            sub_wr_en          = accept && (s_op == OP_SUB) && sub_in_range;
            sub_wr_addr        = SUB_W'(s_sub_index);
            sub_wr_data.active = s_active;
            sub_wr_data.count  = sat_count;
        end
    end

    assign pred_wr_en        = accept && (s_op == OP_PRED) && sub_in_range && slot_in_range;
    assign pred_wr_addr      = {SUB_W'(s_sub_index), SLOT_W'(s_pred_slot)};
    assign pred_wr_data.attr = s_attribute;
    assign pred_wr_data.low  = s_low_bound;
    assign pred_wr_data.high = s_high_bound;

    // Every attribute number is inside the event store, so every pair lands.
    assign event_wr = accept && (s_op == OP_EVENT);

    // Both tables are read every cycle at the address the sequencer will
    // work on next, so the registered read data lines up with the state.
    assign pred_rd_addr = {sub_ptr_reg, k_next};

    always_comb begin
        state_next   = state_reg;
        sub_ptr_next = sub_ptr_reg;
        k_next       = k_reg;
        total_next   = total_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_count_next = m_count_reg;
        clr_present  = 1'b0;
        sub_done     = 1'b0;
        sub_hit      = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                if (sub_last) begin
                    state_next   = ST_IDLE;
                    sub_ptr_next = '0;
                end else begin
                    sub_ptr_next = sub_ptr_reg + SUB_W'(1);
                end
            end
            ST_IDLE: begin
                if (accept && (s_op == OP_EVENT) && s_last) begin
                    state_next   = ST_SUB_CHK;
                    sub_ptr_next = '0;
                    total_next   = '0;
                end
            end
            ST_SUB_CHK: begin
                k_next = '0;
                if (!sub_q.active) begin
                    sub_done = 1'b1;
                end else if (sub_q.count == '0) begin
                    // A subscription without predicates matches any event.
                    sub_done = 1'b1;
                    sub_hit  = 1'b1;
                end else begin
                    state_next = ST_PRED_CHK;
                end
            end
            ST_PRED_CHK: begin
                if (!pred_ok) begin
                    sub_done = 1'b1;
                end else if ((32'(k_reg) + 32'd1) == 32'(sub_q.count)) begin
                    sub_done = 1'b1;
                    sub_hit  = 1'b1;
                end else begin
                    k_next = k_reg + SLOT_W'(1);
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_count_next = total_reg;
                    clr_present  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (sub_hit) begin
            total_next = total_reg + COUNT_W'(1);
        end
        if (sub_done) begin
            if (sub_last) begin
                state_next = ST_DONE;
            end else begin
                sub_ptr_next = sub_ptr_reg + SUB_W'(1);
                state_next   = ST_SUB_CHK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            sub_ptr_reg <= '0;
            k_reg       <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sub_ptr_reg <= sub_ptr_next;
            k_reg       <= k_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_count_reg <= m_count_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_match_count = m_count_reg;

    ism_sub_table #(
        .SUBS  (SUBS),
        .SUB_W (SUB_W)
    ) u_sub_table (
        .aclk    (aclk),
        .wr_en   (sub_wr_en),
        .wr_addr (sub_wr_addr),
        .wr_data (sub_wr_data),
        .rd_addr (sub_ptr_next),
        .rd_data (sub_q)
    );

    ism_pred_table #(
        .DEPTH  (PDEPTH),
        .ADDR_W (PADDR_W)
    ) u_pred_table (
        .aclk    (aclk),
        .wr_en   (pred_wr_en),
        .wr_addr (pred_wr_addr),
        .wr_data (pred_wr_data),
        .rd_addr (pred_rd_addr),
        .rd_data (pred_q)
    );

    ism_event_check u_event_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr_en       (event_wr),
        .wr_attr     (s_attribute),
        .wr_value    (s_event_value),
        .clr_present (clr_present),
        .pred        (pred_q),
        .pred_ok     (pred_ok)
    );

    // A new count appears only at the end of a table walk.
    a_out_from_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("count loaded outside the end of a walk");

    // A final event pair always starts a walk at the first subscription.
    a_walk_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_op == OP_EVENT) && s_last)
        |=> (state_reg == ST_SUB_CHK) && (sub_ptr_reg == '0))
        else $error("final event pair did not start a walk");

    // The predicate slot under test stays below the subscription's count.
    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PRED_CHK) |-> (32'(k_reg) < 32'(sub_q.count)))
        else $error("predicate slot beyond subscription count");

    // The count can never exceed the number of subscriptions.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((SUBS > 2047) || (32'(m_count_reg) <= SUBS)))
        else $error("match count exceeds table size");

    // The clearing pass keeps intake closed right after reset.
    a_clear_first: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_ready)
        else $error("request taken before the clearing pass");

endmodule

/* sim/interval_subscription_matcher_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interval_subscription_matcher_unit_test: self-checking bench for the matcher
// Builds subscription tables and sends events through the request channel.
// Every final event pair is scored by a local model of the table, and the
// match counts that come back are compared in order. A short table of
// directed requests comes first, then random table updates and events.
// ----------------------------------------------------------------------------
module interval_subscription_matcher_unit_test;

    import ism_pkg::*;

    localparam int SUBS        = 1024;
    localparam int MAX_PREDS   = 8;
    localparam int TOTAL_ITEMS = 1850;
    localparam int DIRECTED_ROWS = 21;
    // A count that no request of this kind produces.
    localparam int NO_COUNT    = -1;
    localparam logic [OP_W-1:0]  OP_IDLE = 2'd3;
    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
    // The slowest walk tests every predicate of every subscription.
    localparam int DRAIN_CYCLES = SUBS * (MAX_PREDS + 1) + 64;
    // Every request closing an event with the slowest walk, the clearing
    // pass and every sender gap and receiver stall, taken several times over.
    localparam int CYCLE_LIMIT  = 80_000_000;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [SUB_IDX_W-1:0] sub_index;
        logic [SLOT_IN_W-1:0] pred_slot;
        logic [CNT_W-1:0]     pred_count;
        logic                 active;
        logic [ATTR_W-1:0]    attribute;
        logic [VAL_W-1:0]     low_bound;
        logic [VAL_W-1:0]     high_bound;
        logic [VAL_W-1:0]     event_value;
        logic                 last;
    } request_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [OP_W-1:0]      s_op;
    logic [SUB_IDX_W-1:0] s_sub_index;
    logic [SLOT_IN_W-1:0] s_pred_slot;
    logic [CNT_W-1:0]     s_pred_count;
    logic                 s_active;
    logic [ATTR_W-1:0]    s_attribute;
    logic [VAL_W-1:0]     s_low_bound;
    logic [VAL_W-1:0]     s_high_bound;
    logic [VAL_W-1:0]     s_event_value;
    logic                 s_last;
    logic                 m_valid;
    logic                 m_ready;
    logic [COUNT_W-1:0]   m_match_count;

    // Local copy of the subscription table and of the event being gathered.
    logic [ATTR_W-1:0]    table_attr  [SUBS*MAX_PREDS];
    logic [VAL_W-1:0]     table_low   [SUBS*MAX_PREDS];
    logic [VAL_W-1:0]     table_high  [SUBS*MAX_PREDS];
    logic [CNT_W-1:0]     table_count [SUBS];
    bit                   table_active[SUBS];
    // Slots written since reset; an active entry may only use written slots.
    bit [MAX_PREDS-1:0]   slot_written[SUBS];
    logic [VAL_W-1:0]     event_vals  [DIM];
    bit                   event_seen  [DIM];

    logic [COUNT_W-1:0]   pending_counts[$];
    int                   error_total = 0;
    int                   work_sent   = 0;
    int                   burst_left  = 0;
    int                   cycle_count = 0;

    request_t             directed_reqs  [DIRECTED_ROWS];
    int                   directed_counts[DIRECTED_ROWS];

    interval_subscription_matcher_unit #(
        .SUBS      (SUBS),
        .MAX_PREDS (MAX_PREDS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_sub_index   (s_sub_index),
        .s_pred_slot   (s_pred_slot),
        .s_pred_count  (s_pred_count),
        .s_active      (s_active),
        .s_attribute   (s_attribute),
        .s_low_bound   (s_low_bound),
        .s_high_bound  (s_high_bound),
        .s_event_value (s_event_value),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_match_count (m_match_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        error_total++;
    endtask

    // Updates the local table with one accepted request. Returns the number
    // of matching subscriptions when the request closes an event, and
    // NO_COUNT otherwise.
    function automatic int apply_request(input request_t r);
        int  e;
        int  total;
        int  limit;
        bit  hit;
        logic [ATTR_W-1:0] a;
        total = NO_COUNT;
        case (r.op)
            OP_PRED: begin
                e = int'(r.sub_index) * MAX_PREDS + int'(r.pred_slot);
                table_attr[e] = r.attribute;
                table_low[e]  = r.low_bound;
                table_high[e] = r.high_bound;
                slot_written[r.sub_index][r.pred_slot] = 1'b1;
            end
            OP_SUB: begin
                table_count[r.sub_index]  = (r.pred_count > MAX_PREDS) ? CNT_W'(MAX_PREDS)
                                                                        : r.pred_count;
                table_active[r.sub_index] = r.active;
            end
            OP_EVENT: begin
                event_vals[r.attribute] = r.event_value;
                event_seen[r.attribute] = 1'b1;
                if (r.last) begin
                    total = 0;
                    for (int s = 0; s < SUBS; s++) begin
                        if (table_active[s]) begin
                            hit   = 1'b1;
                            limit = int'(table_count[s]);
                            for (int k = 0; k < limit; k++) begin
                                e = s * MAX_PREDS + k;
                                a = table_attr[e];
                                if (!event_seen[a] || event_vals[a] < table_low[e] ||
                                    event_vals[a] > table_high[e])
                                    hit = 1'b0;
                            end
                            if (hit)
                                total++;
                        end
                    end
                    for (int d = 0; d < DIM; d++)
                        event_seen[d] = 1'b0;
                end
            end
            default: begin
            end
        endcase
        return total;
    endfunction

    // A predicate count that only reaches slots written so far.
    function automatic logic [CNT_W-1:0] legal_count(input int sub);
        int prefix;
        prefix = 0;
        while (prefix < MAX_PREDS && slot_written[sub][prefix])
            prefix++;
        if (prefix == MAX_PREDS)
            return CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
        return CNT_W'($urandom_range(0, prefix));
    endfunction

    // Most values sit in a narrow band so that intervals and events meet.
    function automatic logic [VAL_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return VAL_W'($urandom_range(0, 255));
        if (roll < 85)
            return VAL_MAX - VAL_W'($urandom_range(0, 255));
        return VAL_W'($urandom);
    endfunction

    function automatic logic [ATTR_W-1:0] pick_attr();
        if ($urandom_range(0, 4) != 0)
            return ATTR_W'($urandom_range(0, 5));
        return ATTR_W'($urandom_range(0, DIM - 1));
    endfunction

    // Any request at all, kept legal: it never activates an entry whose
    // counted slots were not all written.
    function automatic request_t noise_request();
        request_t r;
        r.op          = OP_W'($urandom_range(0, 3));
        r.sub_index   = SUB_IDX_W'($urandom_range(0, SUBS - 1));
        r.pred_slot   = SLOT_IN_W'($urandom_range(0, MAX_PREDS - 1));
        r.pred_count  = CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
        r.active      = 1'($urandom_range(0, 1));
        r.attribute   = ATTR_W'($urandom_range(0, DIM - 1));
        r.low_bound   = VAL_W'($urandom);
        r.high_bound  = VAL_W'($urandom);
        r.event_value = VAL_W'($urandom);
        r.last        = 1'($urandom_range(0, 1));
        if (r.op == OP_SUB && r.active)
            r.pred_count = legal_count(int'(r.sub_index));
        return r;
    endfunction

    // Sends one request in bursts with random gaps, waits for the handshake
    // and records the count it is due to produce. A typed count, where
    // given, stands in place of the model's.
    task automatic offer_request(input request_t r, input int typed_count);
        int gap;
        int due;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_op          <= r.op;
        s_sub_index   <= r.sub_index;
        s_pred_slot   <= r.pred_slot;
        s_pred_count  <= r.pred_count;
        s_active      <= r.active;
        s_attribute   <= r.attribute;
        s_low_bound   <= r.low_bound;
        s_high_bound  <= r.high_bound;
        s_event_value <= r.event_value;
        s_last        <= r.last;
        do
            @(posedge aclk);
        while (!(s_valid && s_ready));
        if (r.op != OP_IDLE)
            work_sent++;
        due = apply_request(r);
        if (due != NO_COUNT)
            pending_counts.push_back(COUNT_W'((typed_count != NO_COUNT) ? typed_count : due));
    endtask

    initial begin : stimulus
        request_t r;
        int       row;
        int       kind;
        int       n;
        int       sub;
        int       pairs;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_op          <= '0;
        s_sub_index   <= '0;
        s_pred_slot   <= '0;
        s_pred_count  <= '0;
        s_active      <= 1'b0;
        s_attribute   <= '0;
        s_low_bound   <= '0;
        s_high_bound  <= '0;
        s_event_value <= '0;
        s_last        <= 1'b0;

        directed_reqs = '{
            //  op        sub       slot  cnt    act   attr    low      high     value       last
            // An event with an empty table.
            '{OP_EVENT, 10'd0,    3'd0, 4'd0,  1'b0, 5'd0,   20'd0,   20'd0,   20'd0,      1'b1},
            // The unused operation with every field at its top.
            '{OP_IDLE,  10'd1023, 3'd7, 4'd15, 1'b1, 5'd31,  VAL_MAX, VAL_MAX, VAL_MAX,    1'b1},
            // A subscription with no predicates matches every event.
            '{OP_SUB,   10'd1023, 3'd0, 4'd0,  1'b1, 5'd0,   20'd0,   20'd0,   20'd0,      1'b0},
            '{OP_EVENT, 10'd0,    3'd0, 4'd0,  1'b0, 5'd31,  20'd0,   20'd0,   VAL_MAX,    1'b1},
            '{OP_PRED,  10'd0,    3'd0, 4'd0,  1'b0, 5'd31,  20'd0,   VAL_MAX, 20'd0,      1'b0},
            '{OP_PRED,  10'd0,    3'd1, 4'd0,  1'b0, 5'd7,   20'd100, 20'd200, 20'd0,      1'b0},
            '{OP_SUB,   10'd0,    3'd0, 4'd2,  1'b1, 5'd0,   20'd0,   20'd0,   20'd0,      1'b0},
            // Attribute 7 arrives twice; the later value counts, on the bound.
            '{OP_EVENT, 10'd0,    3'd0, 4'd0,  1'b0, 5'd31,  20'd0,   20'd0,   20'd12345,  1'b0},
            '{OP_EVENT, 10'd0,    3'd0, 4'd0,  1'b0, 5'd7,   20'd0,   20'd0,   20'd50,     1'b0},
            '{OP_EVENT, 10'd0,    3'd0, 4'd0,  1'b0, 5'd7,   20'd0,   20'd0,   20'd200,    1'b1},
            // The previous event is gone, so attribute 31 is missing now.
            '{OP_EVENT, 10'd0,    3'd0, 4'd0,  1'b0, 5'd7,   20'd0,   20'd0,   20'd100,    1'b1},
            // A reversed interval never matches.
            '{OP_PRED,  10'd1,    3'd0, 4'd0,  1'b0, 5'd2,   20'd9,   20'd8,   20'd0,      1'b0},
            '{OP_SUB,   10'd1,    3'd0, 4'd1,  1'b1, 5'd0,   20'd0,   20'd0,   20'd0,      1'b0},
            '{OP_EVENT, 10'd0,    3'd0, 4'd0,  1'b0, 5'd2,   20'd0,   20'd0,   20'd8,      1'b0},
            '{OP_EVENT, 10'd0,    3'd0, 4'd0,  1'b0, 5'd2,   20'd0,   20'd0,   20'd9,      1'b1},
            // A point interval at the top of the value range.
            '{OP_PRED,  10'd2,    3'd0, 4'd0,  1'b0, 5'd4,   VAL_MAX, VAL_MAX, 20'd0,      1'b0},
            '{OP_SUB,   10'd2,    3'd0, 4'd1,  1'b1, 5'd0,   20'd0,   20'd0,   20'd0,      1'b0},
            '{OP_EVENT, 10'd0,    3'd0, 4'd0,  1'b0, 5'd4,   20'd0,   20'd0,   VAL_MAX,    1'b0},
            '{OP_EVENT, 10'd0,    3'd0, 4'd0,  1'b0, 5'd31,  20'd0,   20'd0,   20'd0,      1'b1},
            // Removing the catch-all entry, with a count above the slot limit.
            '{OP_SUB,   10'd1023, 3'd0, 4'd15, 1'b0, 5'd0,   20'd0,   20'd0,   20'd0,      1'b0},
            '{OP_EVENT, 10'd0,    3'd0, 4'd0,  1'b0, 5'd4,   20'd0,   20'd0,   VAL_MAX-20'd1, 1'b1}
        };
        directed_counts = '{0, NO_COUNT, NO_COUNT, 1, NO_COUNT, NO_COUNT, NO_COUNT,
                            NO_COUNT, NO_COUNT, 2, 1, NO_COUNT, NO_COUNT, NO_COUNT, 1,
                            NO_COUNT, NO_COUNT, NO_COUNT, NO_COUNT, NO_COUNT, 0};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (row = 0; row < DIRECTED_ROWS; row++)
            offer_request(directed_reqs[row], directed_counts[row]);

        // Random part: mostly complete subscription definitions and complete
        // events, with stray updates, noise and cut-off sequences mixed in.
        while (work_sent < TOTAL_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                sub = $urandom_range(0, SUBS - 1);
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, MAX_PREDS)
                                                : $urandom_range(1, 3);
                for (int k = 0; k < n; k++) begin
                    r = noise_request();
                    r.op         = OP_PRED;
                    r.sub_index  = SUB_IDX_W'(sub);
                    r.pred_slot  = SLOT_IN_W'(k);
                    r.attribute  = pick_attr();
                    r.low_bound  = pick_value();
                    case ($urandom_range(0, 9))
                        0: r.high_bound = r.low_bound - 1'b1;
                        1: begin
                            r.low_bound  = '0;
                            r.high_bound = VAL_MAX;
                        end
                        default: r.high_bound = (r.low_bound > VAL_MAX - 255) ? VAL_MAX :
                                                r.low_bound + VAL_W'($urandom_range(0, 255));
                    endcase
                    offer_request(r, NO_COUNT);
                end
                r = noise_request();
                r.op         = OP_SUB;
                r.sub_index  = SUB_IDX_W'(sub);
                r.active     = ($urandom_range(0, 9) != 0);
                r.pred_count = (n == MAX_PREDS) ?
                               CNT_W'($urandom_range(MAX_PREDS, (1 << CNT_W) - 1)) : CNT_W'(n);
                offer_request(r, NO_COUNT);
            end else if (kind < 62) begin
                pairs = $urandom_range(1, 6);
                for (int k = 0; k < pairs; k++) begin
                    r = noise_request();
                    r.op          = OP_EVENT;
                    r.attribute   = pick_attr();
                    r.event_value = pick_value();
                    r.last        = (k == pairs - 1);
                    offer_request(r, NO_COUNT);
                end
            end else if (kind < 78) begin
                r = noise_request();
                r.op     = OP_SUB;
                r.active = 1'($urandom_range(0, 1));
                if (r.active)
                    r.pred_count = legal_count(int'(r.sub_index));
                offer_request(r, NO_COUNT);
            end else if (kind < 90) begin
                offer_request(noise_request(), NO_COUNT);
            end else begin
                // Pieces of a sequence left unfinished: predicates that are
                // never enabled, or pairs that run on into the next event.
                pairs = $urandom_range(1, 3);
                for (int k = 0; k < pairs; k++) begin
                    r = noise_request();
                    r.op   = (kind < 95) ? OP_PRED : OP_EVENT;
                    r.last = 1'b0;
                    if (r.op == OP_EVENT) begin
                        r.attribute   = pick_attr();
                        r.event_value = pick_value();
                    end
                    offer_request(r, NO_COUNT);
                end
            end
        end
        s_valid <= 1'b0;

        while (pending_counts.size() != 0)
            @(posedge aclk);
        // Give a stray walk time to show up before closing.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_total == 0)
            $display("PASS interval_subscription_matcher_unit");
        else
            $display("FAIL interval_subscription_matcher_unit");
        $finish;
    end

    // Receiver: switches now and then between always ready, coin-flip
    // stalls and long stretches of mostly not ready.
    initial begin : receiver
        int mode_left;
        int rx_mode;
        mode_left = 0;
        rx_mode   = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 400);
            end
            mode_left--;
            case (rx_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Each count taken from the result channel must be the oldest one due.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_counts.size() == 0)
                flag_mismatch($sformatf("match count %0d with none due", m_match_count));
            else if (m_match_count !== pending_counts[0])
                flag_mismatch($sformatf("match_count %0d, due %0d",
                                        m_match_count, pending_counts[0]));
            if (pending_counts.size() != 0)
                void'(pending_counts.pop_front());
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d counts still due",
                     cycle_count, pending_counts.size());
            $display("FAIL interval_subscription_matcher_unit");
            $finish;
        end
    end

endmodule
